[hw/rtl/itpt_pkg.sv]
// Shared types, constants and helper functions for the integer-to-text formatter.
package itpt_pkg;

	// Default internal text buffer size, including the unused terminator slot.
	localparam int ITPT_BUF_SIZE = 16;

	// Upper bound on characters emitted for one number.
	localparam int MAX_CHARS = 15;

	// Reciprocal of ten for a 32-bit dividend: q = (x * DEC_RECIP) >> DEC_SHIFT.
	localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
	localparam int DEC_SHIFT = 35;

	// Offset from the character after '9' up to 'A'.
	localparam logic [7:0] HEX_GAP = 8'd7;

	// Fixed characters.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// One number to format.
	typedef struct packed {
		logic [31:0] value;
		logic        is_hex;
		logic        is_signed;
		logic [3:0]  min_width;
		logic        zero_pad;
	} num_item_t;

	// One emitted character.
	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} txt_item_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIG,
		ST_EMIT
	} itpt_state_t;

	// Converts a digit value to its uppercase ASCII character.
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] ch;
		ch = {4'h0, d} + CHAR_ZERO;
		if (ch > CHAR_NINE) begin
			ch = ch + HEX_GAP;
		end
		return ch;
	endfunction

endpackage

[hw/rtl/itpt_digit_unit.sv]
// Shared digit extraction unit: divides by ten or sixteen, one digit per step.
module itpt_digit_unit
	import itpt_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] operand,
	input  logic        is_hex,
	output logic [31:0] quot,
	output logic [3:0]  rem
);

	logic [63:0] prod_s1;
	logic [31:0] dec_quot;
	logic [31:0] dec_times10;
	logic [31:0] dec_rem;

	// The reciprocal product is registered; the operand must hold for one more cycle.
	always_ff @(posedge clk) begin
		prod_s1 <= {32'h0, operand} * {32'h0, DEC_RECIP};
	end

	// Decimal quotient and remainder from the registered product.
	always_comb begin
		dec_quot    = 32'(prod_s1[63:DEC_SHIFT]);
		dec_times10 = (dec_quot << 3) + (dec_quot << 1);
		dec_rem     = operand - dec_times10;
	end

	// Hex needs only a shift and a mask.
	always_comb begin
		if (is_hex) begin
			quot = operand >> 4;
			rem  = operand[3:0];
		end else begin
			quot = dec_quot;
			rem  = dec_rem[3:0];
		end
	end

endmodule

[hw/rtl/integer_to_padded_text.sv]
// Top level of the integer-to-text formatter: sequencer, digit store and output register.
//
//  Channel | Direction | Handshake            | Payload
//  num     | in        | num_valid/num_stall  | num_item_t (value, radix, sign, width, pad)
//  txt     | out       | txt_valid/txt_stall  | txt_item_t (out_char, last)
//
// A number is accepted in the idle state. Each digit then takes a multiply step and a remainder
// step in the shared digit unit, and the characters are then emitted one per cycle while txt
// is not stalled.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// A stall on txt holds the current character; num is stalled until the last
// character has been loaded into the output register.
module integer_to_padded_text
	import itpt_pkg::*;
#(
	parameter int BUF_SIZE = ITPT_BUF_SIZE
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      num_valid,
	output logic      num_stall,
	input  num_item_t num,
	output logic      txt_valid,
	input  logic      txt_stall,
	output txt_item_t txt
);

	localparam int DEPTH = BUF_SIZE - 1;
	localparam int CW    = $clog2(BUF_SIZE);
	localparam int IW    = $clog2(DEPTH);

	itpt_state_t state_q, state_d;

	logic [31:0]   val_q;
	logic          hex_q;
	logic          neg_q;
	logic          zpad_q;
	logic [3:0]    width_q;
	logic [CW-1:0] ndig_q;
	logic [CW-1:0] k_q;
	logic [3:0]    dig_q [DEPTH];
	logic          txt_valid_q;
	txt_item_t     txt_q;

	logic [31:0]   quot;
	logic [3:0]    rem;
	logic          accept;
	logic          in_neg;
	logic          dig_done;
	logic          out_free;
	logic          load_char;
	logic          sign_fit;
	logic [CW-1:0] len;
	logic [CW-1:0] wclip;
	logic [CW-1:0] total;
	logic [CW-1:0] nchars;
	logic [CW-1:0] pad_cnt;
	logic [CW-1:0] ridx;
	logic [7:0]    cur_char;
	logic          cur_last;

	itpt_digit_unit u_digit (
		.clk     (clk),
		.operand (val_q),
		.is_hex  (hex_q),
		.quot    (quot),
		.rem     (rem)
	);

	// Handshake decode.
	always_comb begin
		num_stall = (state_q != ST_IDLE);
		accept    = num_valid && (state_q == ST_IDLE);
		in_neg    = !num.is_hex && num.is_signed && num.value[31];
		dig_done  = (quot == 32'h0) || (ndig_q + CW'(1) == CW'(DEPTH));
		out_free  = !txt_valid_q || !txt_stall;
	end

	// Field layout: padding, then the sign, then the digits.
	always_comb begin
		sign_fit = neg_q && (ndig_q != CW'(DEPTH));
		len      = ndig_q + CW'(sign_fit);
		wclip    = (CW'(width_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(width_q);
		total    = (len > wclip) ? len : wclip;
		nchars   = (total > CW'(MAX_CHARS)) ? CW'(MAX_CHARS) : total;
		pad_cnt  = total - len;
		ridx     = total - CW'(1) - k_q;
		cur_last = (k_q + CW'(1) == nchars);
		if (k_q < pad_cnt) begin
			cur_char = zpad_q ? CHAR_ZERO : CHAR_SPACE;
		end else if (sign_fit && (k_q == pad_cnt)) begin
			cur_char = CHAR_MINUS;
		end else begin
			cur_char = digit_char(dig_q[ridx[IW-1:0]]);
		end
	end

	// Next state and character load.
	always_comb begin
		state_d   = state_q;
		load_char = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIG;
			end
			ST_DIG: begin
				state_d = dig_done ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (out_free) begin
					load_char = 1'b1;
					if (cur_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Operand, options and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
			k_q    <= '0;
		end else begin
			if (accept) begin
				ndig_q <= '0;
				k_q    <= '0;
			end else if (state_q == ST_DIG) begin
				ndig_q <= ndig_q + CW'(1);
			end else if (load_char) begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q   <= in_neg ? (32'h0 - num.value) : num.value;
			hex_q   <= num.is_hex;
			neg_q   <= in_neg;
			zpad_q  <= num.zero_pad;
			width_q <= num.min_width;
		end else if (state_q == ST_DIG) begin
			val_q <= quot;
		end
	end

	// Digit store, least significant digit at index zero.
	always_ff @(posedge clk) begin
		if (state_q == ST_DIG) begin
			dig_q[ndig_q[IW-1:0]] <= rem;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_valid_q <= 1'b0;
		end else if (load_char) begin
			txt_valid_q <= 1'b1;
		end else if (!txt_stall) begin
			txt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_char) begin
			txt_q.out_char <= cur_char;
			txt_q.last     <= cur_last;
		end
	end

	assign txt_valid = txt_valid_q;
	assign txt       = txt_q;

endmodule

[bench/integer_to_padded_text_tb.sv]
// Self-checking testbench for integer_to_padded_text: directed table, random numbers, stalls.
`timescale 1ns / 1ps

module integer_to_padded_text_tb
	import itpt_pkg::*;
();

	localparam int BUF_LEN = ITPT_BUF_SIZE;
	localparam int RESET_CYCLES = 12;
	localparam int DIR_ROWS = 21;
	localparam int RANDOM_ITEMS = 80;
	localparam int CALM_ITEMS = 20;
	localparam int HOLD_AFTER = 50;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      num_valid;
	logic      num_stall;
	num_item_t num;
	logic      txt_valid;
	logic      txt_stall;
	txt_item_t txt;

	// Characters still owed by the block, oldest first, and the typed text per number sent.
	txt_item_t pending_chars [$];
	string     pending_text [$];

	num_item_t dir_items [DIR_ROWS];
	string     dir_text [DIR_ROWS];

	int  mismatch_count = 0;
	int  nums_accepted = 0;
	int  hex_count = 0;
	int  negative_count = 0;
	int  chars_checked = 0;
	int  cycle_count = 0;
	bit  calm = 1'b0;

	integer_to_padded_text uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.num       (num),
		.txt_valid (txt_valid),
		.txt_stall (txt_stall),
		.txt       (txt)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Computes the padded text of one number and queues its characters.
	function automatic void format_number(input num_item_t item);
		logic [7:0]  text [BUF_LEN];
		logic [31:0] mag;
		logic [31:0] radix;
		logic [31:0] digit;
		logic        neg;
		int          pos;
		int          floor_pos;
		int          width;
		int          count;
		txt_item_t   ch;
		mag = item.value;
		radix = item.is_hex ? 32'd16 : 32'd10;
		neg = 1'b0;
		pos = BUF_LEN - 1;
		if (!item.is_hex && item.is_signed && mag[31]) begin
			mag = 32'd0 - mag;
			neg = 1'b1;
		end
		// Digits go in from the right, least significant first.
		do begin
			digit = mag % radix;
			pos--;
			if (digit < 32'd10) begin
				text[pos] = CHAR_ZERO + digit[7:0];
			end else begin
				text[pos] = CHAR_UPPER_A + digit[7:0] - 8'd10;
			end
			mag = mag / radix;
		end while (pos != 0 && mag != 0);
		if (pos != 0 && neg) begin
			pos--;
			text[pos] = CHAR_MINUS;
		end
		// Padding sits in front of the sign, up to the clipped width.
		width = item.min_width;
		if (width > BUF_LEN - 1) begin
			width = BUF_LEN - 1;
		end
		floor_pos = BUF_LEN - 1 - width;
		while (pos != 0 && pos > floor_pos) begin
			pos--;
			text[pos] = item.zero_pad ? CHAR_ZERO : CHAR_SPACE;
		end
		count = BUF_LEN - 1 - pos;
		if (count > MAX_CHARS) begin
			count = MAX_CHARS;
		end
		for (int k = 0; k < count; k++) begin
			ch.out_char = text[pos + k];
			ch.last = (k + 1 == count);
			pending_chars.push_back(ch);
		end
	endfunction

	function automatic num_item_t make_num(input logic [31:0] value, input bit hex,
			input bit sgn, input int width, input bit zpad);
		num_item_t item;
		item.value = value;
		item.is_hex = hex;
		item.is_signed = sgn;
		item.min_width = 4'(width);
		item.zero_pad = zpad;
		return item;
	endfunction

	// Random number with a bias toward short values and the sign boundary.
	function automatic num_item_t random_number();
		num_item_t item;
		item.is_hex = $urandom_range(0, 1) != 0;
		item.is_signed = $urandom_range(0, 1) != 0;
		item.min_width = 4'($urandom_range(0, 15));
		item.zero_pad = $urandom_range(0, 1) != 0;
		case ($urandom_range(0, 4))
			0: item.value = $urandom;
			1: item.value = $urandom_range(0, 99);
			2: item.value = 32'd0 - $urandom_range(1, 999);
			3: item.value = $urandom >> $urandom_range(0, 31);
			default: begin
				case ($urandom_range(0, 3))
					0: item.value = 32'h8000_0000;
					1: item.value = 32'h7FFF_FFFF;
					2: item.value = 32'hFFFF_FFFF;
					default: item.value = 32'h0000_0000;
				endcase
			end
		endcase
		return item;
	endfunction

	// Offers one number and returns after the edge that accepts it.
	task automatic offer_number(input num_item_t item, input string text);
		pending_text.push_back(text);
		@(negedge clk);
		num = item;
		num_valid = 1'b1;
		@(posedge clk);
		while (num_stall) begin
			@(posedge clk);
		end
	endtask

	// Sender gap with valid low and junk on the payload.
	task automatic sender_pause();
		logic [63:0] noise;
		int          gap;
		gap = $urandom_range(1, 3);
		repeat (gap) begin
			@(negedge clk);
			noise = {$urandom, $urandom};
			num_valid = 1'b0;
			num = noise[$bits(num_item_t)-1:0];
		end
	endtask

	// Receiver: random stall bursts, plus one long hold-off that backs the block up.
	initial begin : receiver_side
		int  burst;
		int  held;
		bit  hold_done;
		txt_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && nums_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				txt_stall = 1'b1;
				held = 1;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 3);
				txt_stall = 1'b1;
				repeat (burst - 1) @(negedge clk);
			end else begin
				txt_stall = 1'b0;
			end
		end
	end

	// Port monitor: predicts on each accepted number, checks each accepted character.
	always @(posedge clk) begin : port_monitor
		string     typed;
		txt_item_t want;
		txt_item_t ch;
		if (arst_n) begin
			if (num_valid && !num_stall) begin
				typed = pending_text.pop_front();
				if (typed.len() != 0) begin
					for (int k = 0; k < typed.len(); k++) begin
						ch.out_char = typed[k];
						ch.last = (k + 1 == typed.len());
						pending_chars.push_back(ch);
					end
				end else begin
					format_number(num);
				end
				nums_accepted++;
				if (num.is_hex) begin
					hex_count++;
				end else if (num.is_signed && num.value[31]) begin
					negative_count++;
				end
			end
			if (txt_valid && !txt_stall) begin
				if (pending_chars.size() == 0) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display("unexpected character 0x%02h last %0b with nothing pending",
							txt.out_char, txt.last);
					end
					mismatch_count++;
				end else begin
					want = pending_chars.pop_front();
					chars_checked++;
					if (txt.out_char !== want.out_char || txt.last !== want.last) begin
						if (mismatch_count < MAX_REPORTS) begin
							$display("mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
								want.out_char, want.last, txt.out_char, txt.last);
						end
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog on total run length.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("integer_to_padded_text verification failed");
		$finish;
	end

	// Stimulus: reset, directed table, random numbers, then drain.
	initial begin : stimulus
		num_valid = 1'b0;
		num = '0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Value, hex, signed, width, zero pad; empty text means the predictor decides.
		dir_items = '{
			make_num(32'h0000_0000, 0, 0, 0, 0),
			make_num(32'h0000_0000, 1, 0, 0, 0),
			make_num(32'hFFFF_FFFF, 0, 0, 0, 0),
			make_num(32'hFFFF_FFFF, 1, 0, 0, 0),
			make_num(32'hFFFF_FFFF, 0, 1, 0, 0),
			make_num(32'h8000_0000, 0, 1, 0, 0),
			make_num(32'h8000_0000, 0, 0, 0, 0),
			make_num(32'h7FFF_FFFF, 0, 1, 0, 0),
			make_num(32'hFFFF_FFFB, 0, 1, 4, 1),
			make_num(32'hFFFF_FFFB, 0, 1, 4, 0),
			make_num(32'h0000_0000, 0, 0, 15, 1),
			make_num(32'hFFFF_FFFF, 1, 0, 15, 0),
			make_num(32'h8000_0000, 0, 1, 15, 1),
			make_num(32'hABCD_EF01, 1, 1, 0, 0),
			make_num(32'h0000_001F, 1, 0, 4, 1),
			make_num(32'hFFFF_FF85, 0, 1, 2, 0),
			make_num(32'h0000_000A, 0, 0, 1, 0),
			make_num(32'h1234_5678, 1, 0, 3, 1),
			make_num(32'h5A5A_5A5A, 0, 1, 12, 1),
			make_num(32'hA5A5_A5A5, 0, 1, 14, 0),
			make_num(32'h0000_FFFF, 0, 0, 8, 0)
		};
		dir_text = '{
			"0",
			"0",
			"4294967295",
			"FFFFFFFF",
			"-1",
			"-2147483648",
			"2147483648",
			"2147483647",
			"00-5",
			"  -5",
			"000000000000000",
			"       FFFFFFFF",
			"0000-2147483648",
			"ABCDEF01",
			"001F",
			"-123",
			"10",
			"",
			"",
			"",
			""
		};

		// Output must be idle straight out of reset.
		@(posedge clk);
		if (txt_valid !== 1'b0) begin
			$display("txt_valid is %b after reset, expected 0", txt_valid);
			mismatch_count++;
		end

		for (int i = 0; i < DIR_ROWS; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				sender_pause();
			end
			offer_number(dir_items[i], dir_text[i]);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS) begin
				calm = 1'b1;
			end
			if (!calm && $urandom_range(0, 3) == 0) begin
				sender_pause();
			end
			offer_number(random_number(), "");
		end
		@(negedge clk);
		num_valid = 1'b0;

		while (pending_chars.size() != 0 || pending_text.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			$display("%0d characters never arrived", pending_chars.size());
			mismatch_count++;
		end

		$display("Formatted %0d numbers (%0d hex, %0d negative signed) in %0d cycles,",
			nums_accepted, hex_count, negative_count, cycle_count);
		$display("checked %0d characters under random stalls and one long output hold-off; %0d failures.",
			chars_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("integer_to_padded_text verification clean");
		end else begin
			$display("integer_to_padded_text verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/itpt_pkg.sv
hw/rtl/itpt_digit_unit.sv
hw/rtl/integer_to_padded_text.sv
bench/integer_to_padded_text_tb.sv
